// ===== rtl/core/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants, codes and types of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

   localparam int COORD_BITS   = 11;
   localparam int DELTA_BITS   = COORD_BITS + 1;
   localparam int INC_BITS     = COORD_BITS + 1;
   localparam int DEC_BITS     = COORD_BITS + 3;
   localparam int REQ_RAW_BITS = 4 * COORD_BITS;
   localparam int REQ_BITS     = ((REQ_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS = 2 * COORD_BITS;
   localparam int RSP_BITS     = ((RSP_RAW_BITS + 7) / 8) * 8;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // octant bit 0: x steps negative, bit 1: y steps negative, bit 2: y major
   localparam int OCT_X_NEG   = 0;
   localparam int OCT_Y_NEG   = 1;
   localparam int OCT_Y_MAJOR = 2;

   typedef struct packed {
      logic [2:0]                 octant;
      logic [COORD_BITS-1:0]      major_len;
      logic signed [DEC_BITS-1:0] decision;
      logic [INC_BITS-1:0]        straight;
      logic signed [DEC_BITS-1:0] diagonal;
   } setup_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
   } pixel_type;

endpackage

// ===== rtl/core/mlr_setup.sv =====
// ----------------------------------------------------------------------------
// mlr_setup
// Line setup: octant, major length and decision terms from the end points.
// ----------------------------------------------------------------------------
module mlr_setup import mlr_pkg::*; (
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  logic signed [COORD_BITS-1:0] x_end,
   input  logic signed [COORD_BITS-1:0] y_end,
   output setup_type                    setup
);

   logic signed [DELTA_BITS-1:0] dx;
   logic signed [DELTA_BITS-1:0] dy;
   logic [DELTA_BITS-1:0]        adx_full;
   logic [DELTA_BITS-1:0]        ady_full;
   logic [COORD_BITS-1:0]        adx;
   logic [COORD_BITS-1:0]        ady;
   logic [COORD_BITS-1:0]        maj;
   logic [COORD_BITS-1:0]        mnr;
   logic signed [DEC_BITS-1:0]   diff;

   always_comb begin
      dx       = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
      dy       = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
      adx_full = dx[DELTA_BITS-1] ? -dx : dx;
      ady_full = dy[DELTA_BITS-1] ? -dy : dy;
      adx      = adx_full[COORD_BITS-1:0];
      ady      = ady_full[COORD_BITS-1:0];
      setup.octant[OCT_X_NEG] = dx[DELTA_BITS-1];
      setup.octant[OCT_Y_NEG] = dy[DELTA_BITS-1];
      if (adx >= ady) begin
         maj = adx;
         mnr = ady;
         setup.octant[OCT_Y_MAJOR] = 1'b0;
      end else begin
         maj = ady;
         mnr = adx;
         setup.octant[OCT_Y_MAJOR] = 1'b1;
      end
      diff           = $signed({3'b000, mnr}) - $signed({3'b000, maj});
      setup.major_len = maj;
      setup.decision  = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
      setup.straight  = {mnr, 1'b0};
      setup.diagonal  = {diff[DEC_BITS-2:0], 1'b0};
   end

endmodule

// ===== rtl/core/mlr_walker.sv =====
// ----------------------------------------------------------------------------
// mlr_walker
// Line state and one midpoint step per item; forms the next pixel.
// ----------------------------------------------------------------------------
module mlr_walker import mlr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  op_type                       op,
   input  logic signed [COORD_BITS-1:0] x_start,
   input  logic signed [COORD_BITS-1:0] y_start,
   input  setup_type                    setup,
   output logic                         has_result,
   output pixel_type                    pixel
);

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        remain_ff, remain_in;
   logic signed [DEC_BITS-1:0]   decision_ff, decision_in;
   logic [INC_BITS-1:0]          straight_ff, straight_in;
   logic signed [DEC_BITS-1:0]   diagonal_ff, diagonal_in;
   logic [2:0]                   octant_ff, octant_in;
   logic                         active_ff, active_in;

   logic                         diag;
   logic                         move_x;
   logic                         move_y;
   logic [COORD_BITS-1:0]        remain_dec;

   always_comb begin
      diag       = decision_ff > 0;
      move_x     = octant_ff[OCT_Y_MAJOR] ? diag : 1'b1;
      move_y     = octant_ff[OCT_Y_MAJOR] ? 1'b1 : diag;
      remain_dec = remain_ff - 1'b1;
      has_result = (op == OP_LOAD) || active_ff;

      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      remain_in   = remain_ff;
      decision_in = decision_ff;
      straight_in = straight_ff;
      diagonal_in = diagonal_ff;
      octant_in   = octant_ff;
      active_in   = active_ff;

      if (op == OP_LOAD) begin
         cur_x_in    = x_start;
         cur_y_in    = y_start;
         remain_in   = setup.major_len;
         decision_in = setup.decision;
         straight_in = setup.straight;
         diagonal_in = setup.diagonal;
         octant_in   = setup.octant;
         active_in   = setup.major_len != '0;
      end else if (active_ff) begin
         if (move_x) begin
            cur_x_in = octant_ff[OCT_X_NEG] ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
         if (move_y) begin
            cur_y_in = octant_ff[OCT_Y_NEG] ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
         decision_in = diag ? decision_ff + diagonal_ff
                            : decision_ff + $signed({2'b00, straight_ff});
         remain_in   = remain_dec;
         active_in   = remain_dec != '0;
      end

      pixel.x    = cur_x_in;
      pixel.y    = cur_y_in;
      pixel.last = !active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         remain_ff <= '0;
      end else if (fire) begin
         active_ff <= active_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         decision_ff <= decision_in;
         straight_ff <= straight_in;
         diagonal_ff <= diagonal_in;
         octant_ff   <= octant_in;
      end
   end

   a_active_matches_count: assert property (@(posedge clock) disable iff (reset)
      active_ff == (remain_ff != '0))
      else $error("active flag disagrees with remaining count");

   a_decision_bounded: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> decision_ff <= $signed({2'b00, straight_ff}))
      else $error("decision term above straight increment");

endmodule

// ===== rtl/core/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer for all eight octants.
// Takes one beat per clock and gives one pixel per clock while the line lasts,
// unless rsp_tready holds a pixel back; a beat passes through an input
// register, one setup-and-step stage and a result register. A load beat
// (tuser 0) starts a line and returns its start pixel, an advance beat
// (tuser 1) returns the next pixel, and an advance with no active line
// returns nothing. tlast marks the end point of the line.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer import mlr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // x_start, y_start, x_end, y_end
   input  logic                req_tuser,   // op
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // pixel_x, pixel_y
   output logic                rsp_tlast    // last_pixel
);

   logic                         in_valid_ff, in_valid_in;
   op_type                       in_op_ff;
   logic signed [COORD_BITS-1:0] in_x0_ff, in_y0_ff, in_x1_ff, in_y1_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   pixel_type                    rsp_pixel_ff;

   logic                         req_fire;
   logic                         advance;
   logic                         has_result;
   setup_type                    setup;
   pixel_type                    pixel;

   mlr_setup u_setup (
      .x_start (in_x0_ff),
      .y_start (in_y0_ff),
      .x_end   (in_x1_ff),
      .y_end   (in_y1_ff),
      .setup   (setup)
   );

   mlr_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .op         (in_op_ff),
      .x_start    (in_x0_ff),
      .y_start    (in_y0_ff),
      .setup      (setup),
      .has_result (has_result),
      .pixel      (pixel)
   );

   always_comb begin
      advance      = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_fire     = req_tvalid && req_tready;
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = (advance && has_result) ? 1'b1
                   : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff <= op_type'(req_tuser);
         in_x0_ff <= req_tdata[COORD_BITS-1:0];
         in_y0_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         in_x1_ff <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
         in_y1_ff <= req_tdata[4*COORD_BITS-1:3*COORD_BITS];
      end
      if (advance && has_result) begin
         rsp_pixel_ff <= pixel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-RSP_RAW_BITS){1'b0}}, rsp_pixel_ff.y, rsp_pixel_ff.x};
   assign rsp_tlast  = rsp_pixel_ff.last;

   a_result_registered: assert property (@(posedge clock) disable iff (reset)
      advance && has_result |=> rsp_valid_ff)
      else $error("stepped pixel not held in result register");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_x0_ff) && $stable(in_op_ff))
      else $error("stalled item lost from input register");

endmodule
